[design/gwwu_pkg.sv]
package gwwu_pkg;

   // Character codes
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   // Word buffer depth default
   localparam int MAX_WORD_DEFAULT = 32;

   // Configuration space
   localparam int         CSR_ADDR_W       = 3;
   localparam logic       REG_LINE_WIDTH   = 1'b0;
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd50;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_WORD,
      ST_EOL
   } seq_state_type;

endpackage

[design/gwwu_ifs.sv]
// Input channel: one text byte per item
interface gwwu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_paragraph;

   modport source (output valid, output in_char, output end_of_paragraph, input ready);
   modport sink   (input valid, input in_char, input end_of_paragraph, output ready);
endinterface

// Result channel: one formatted byte per item
interface gwwu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface

[design/greedy_word_wrap_unit.sv]
// Channel  Direction  Payload                          Handshake
// req_ch   in         in_char[7:0], end_of_paragraph   valid / ready
// rsp_ch   out        out_char[7:0], last              valid / ready
// csr_*    in         line_width at byte address 0     APB write, pready tied high
//
// A word byte is taken while idle and written to the word memory.
// A separator or paragraph end is accepted while idle; the flush state then sends the space
// or line break (none at a line start), the word bytes in order from the word memory, and
// for a paragraph end the closing newline; each byte is stored once and sent once.
// Reset is synchronous; the word memory needs no clearing pass.
// A stalled result channel holds the sequencer; input is taken only while idle.
module greedy_word_wrap_unit #(
   parameter int MAX_WORD = gwwu_pkg::MAX_WORD_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   gwwu_req_if.sink                        req_ch,
   gwwu_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gwwu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = $clog2(MAX_WORD);

   logic [7:0]       line_width_ff, line_width_in;
   logic             reg_hit;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;

   // Configuration register
   assign reg_hit    = (csr_paddr[2] == gwwu_pkg::REG_LINE_WIDTH);
   assign csr_pready = 1'b1;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         line_width_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= gwwu_pkg::LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   assign csr_prdata = reg_hit ? {24'd0, line_width_ff} : 32'd0;

   gwwu_ctrl #(
      .MAX_WORD (MAX_WORD)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .line_width  (line_width_ff),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   gwwu_word_mem #(
      .MAX_WORD (MAX_WORD)
   ) u_word_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[design/gwwu_word_mem.sv]
module gwwu_word_mem #(
   parameter int MAX_WORD = gwwu_pkg::MAX_WORD_DEFAULT,
   localparam int IDX_W   = $clog2(MAX_WORD)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [MAX_WORD];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gwwu_ctrl.sv]
module gwwu_ctrl #(
   parameter int MAX_WORD = gwwu_pkg::MAX_WORD_DEFAULT,
   localparam int IDX_W   = $clog2(MAX_WORD),
   localparam int WL_W    = $clog2(MAX_WORD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       line_width,
   gwwu_req_if.sink         req,
   gwwu_rsp_if.source       rsp,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output logic [7:0]       mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  logic [7:0]       mem_rd_data
);

   localparam int SUM_W = ((WL_W > 8) ? WL_W : 8) + 2;

   gwwu_pkg::seq_state_type state_ff, state_in;
   logic             eop_ff, eop_in;
   logic [WL_W-1:0]  wl_ff, wl_in;
   logic [7:0]       ll_ff, ll_in;
   logic             ls_ff, ls_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;

   logic             slot_free;
   logic             is_sep;
   logic [SUM_W-1:0] fit_sum;
   logic             overflow;
   logic             word_end;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign is_sep    = (req.in_char == gwwu_pkg::CH_SPACE) ||
                      (req.in_char == gwwu_pkg::CH_NEWLINE);
   // Width check counts the separating space
   assign fit_sum   = SUM_W'(ll_ff) + SUM_W'(1) + SUM_W'(wl_ff);
   assign overflow  = fit_sum > SUM_W'(line_width);
   assign word_end  = (WL_W'(idx_ff) == wl_ff - WL_W'(1));

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      eop_in       = eop_ff;
      wl_in        = wl_ff;
      ll_in        = ll_ff;
      ls_in        = ls_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      req.ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wl_ff[IDX_W-1:0];
      mem_wr_data  = req.in_char;

      case (state_ff)
         gwwu_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               eop_in = req.end_of_paragraph;
               // Buffer word bytes, drop those beyond the buffer
               if (!is_sep && (wl_ff < WL_W'(MAX_WORD))) begin
                  mem_wr_en = 1'b1;
                  wl_in     = wl_ff + WL_W'(1);
               end
               if (is_sep || req.end_of_paragraph) begin
                  state_in = gwwu_pkg::ST_PREFIX;
               end
            end
         end
         gwwu_pkg::ST_PREFIX: begin
            if (wl_ff == '0) begin
               // Empty word: nothing to flush
               state_in = eop_ff ? gwwu_pkg::ST_EOL : gwwu_pkg::ST_IDLE;
            end else if (ls_ff) begin
               // No break at the start of a line
               ll_in    = 8'(wl_ff);
               ls_in    = 1'b0;
               idx_in   = '0;
               state_in = gwwu_pkg::ST_WORD;
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               if (overflow) begin
                  out_char_in = gwwu_pkg::CH_NEWLINE;
                  ll_in       = 8'(wl_ff);
               end else begin
                  out_char_in = gwwu_pkg::CH_SPACE;
                  ll_in       = fit_sum[7:0];
               end
               idx_in   = '0;
               state_in = gwwu_pkg::ST_WORD;
            end
         end
         gwwu_pkg::ST_WORD: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = mem_rd_data;
               out_last_in  = word_end && !eop_ff;
               if (word_end) begin
                  idx_in   = '0;
                  wl_in    = '0;
                  state_in = eop_ff ? gwwu_pkg::ST_EOL : gwwu_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         gwwu_pkg::ST_EOL: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = gwwu_pkg::CH_NEWLINE;
               out_last_in  = 1'b1;
               ll_in        = '0;
               ls_in        = 1'b1;
               state_in     = gwwu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gwwu_pkg::ST_IDLE;
         end
      endcase
   end

   // Read address follows the next emit index, so the registered read port holds the byte for the current emit index
   assign mem_rd_addr = idx_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gwwu_pkg::ST_IDLE;
         eop_ff       <= 1'b0;
         wl_ff        <= '0;
         ll_ff        <= '0;
         ls_ff        <= 1'b1;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eop_ff       <= eop_in;
         wl_ff        <= wl_in;
         ll_ff        <= ll_in;
         ls_ff        <= ls_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_char = out_char_ff;
   assign rsp.last     = out_last_ff;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int WORD_CAP = gwwu_pkg::MAX_WORD_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LINE_WIDTH_BYTE = 4 * int'(gwwu_pkg::REG_LINE_WIDTH);
   localparam logic [gwwu_pkg::CSR_ADDR_W-1:0] LINE_WIDTH_ADDR =
      LINE_WIDTH_BYTE[gwwu_pkg::CSR_ADDR_W-1:0];

   typedef struct {
      logic [7:0]  ch;
      logic        eop;
      int unsigned gap;
   } text_item_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } wrap_byte_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [gwwu_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gwwu_req_if req_if();
   gwwu_rsp_if rsp_if();

   greedy_word_wrap_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Text waiting to be sent, and wrapped bytes still owed by the block
   text_item_type pending_text[$];
   wrap_byte_type wrapped_bytes[$];
   int unsigned pushed_count;
   int unsigned accepted_count;
   int unsigned error_count;
   int unsigned cycle_count;
   bit          send_calm;
   bit          rsp_calm;
   int unsigned rsp_stall;
   text_item_type next_item;

   // Wrap state mirrored from the block
   logic [7:0]  word_buf[WORD_CAP];
   int unsigned word_len;
   logic [7:0]  line_len;
   bit          at_line_start;
   logic [7:0]  line_width;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Wrap predictor
   // ---------------------------------------------------------------
   function automatic int put_wrapped(logic [7:0] c);
      wrapped_bytes.push_back('{c, 1'b0});
      return 1;
   endfunction

   // Emit the buffered word with its space or line break in front, none at a line start
   function automatic int flush_word_bytes();
      int n;
      n = 0;
      if (word_len == 0) return 0;
      if (at_line_start) begin
         line_len = word_len[7:0];
         at_line_start = 1'b0;
      end else if (int'(line_len) + 1 + int'(word_len) > int'(line_width)) begin
         n += put_wrapped(gwwu_pkg::CH_NEWLINE);
         line_len = word_len[7:0];
      end else begin
         n += put_wrapped(gwwu_pkg::CH_SPACE);
         line_len = line_len + 8'd1 + word_len[7:0];
      end
      for (int i = 0; i < word_len; i++) n += put_wrapped(word_buf[i]);
      word_len = 0;
      return n;
   endfunction

   function automatic void wrap_char(logic [7:0] c, logic eop);
      int n;
      n = 0;
      if (c == gwwu_pkg::CH_SPACE || c == gwwu_pkg::CH_NEWLINE) begin
         n += flush_word_bytes();
      end else if (word_len < WORD_CAP) begin
         word_buf[word_len] = c;
         word_len++;
      end
      // paragraph end: pending word, then a closing newline
      if (eop) begin
         n += flush_word_bytes();
         n += put_wrapped(gwwu_pkg::CH_NEWLINE);
         line_len = 8'd0;
         at_line_start = 1'b1;
      end
      if (n > 0) wrapped_bytes[wrapped_bytes.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_wrapped_byte(logic [7:0] ch, logic last);
      wrap_byte_type want;
      if (wrapped_bytes.size() == 0) begin
         $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                  $time, ch, last);
         error_count++;
         return;
      end
      want = wrapped_bytes.pop_front();
      if (want.ch !== ch) begin
         $display("%0t: out_char mismatch, expected %02h, actual %02h", $time, want.ch, ch);
         error_count++;
      end
      if (want.last !== last) begin
         $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Driver: sends pending text, each item after its own gap
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.in_char <= 8'd0;
         req_if.end_of_paragraph <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            wrap_char(req_if.in_char, req_if.end_of_paragraph);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_text.size() != 0 && pending_text[0].gap != 0) begin
               pending_text[0].gap = pending_text[0].gap - 1;
               req_if.valid <= 1'b0;
            end else if (pending_text.size() != 0) begin
               next_item = pending_text.pop_front();
               req_if.valid <= 1'b1;
               req_if.in_char <= next_item.ch;
               req_if.end_of_paragraph <= next_item.eop;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random stalls on the result side, compare each byte
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_wrapped_byte(rsp_if.out_char, rsp_if.last);
            if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         if (rsp_stall != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("greedy_word_wrap_unit verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void add_item(logic [7:0] c, logic eop);
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      pending_text.push_back('{c, eop, send_calm ? 0 : $urandom_range(0, 13)});
      pushed_count++;
   endfunction

   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == gwwu_pkg::CH_SPACE || b == gwwu_pkg::CH_NEWLINE);
      return b;
   endfunction

   function automatic logic [7:0] separator();
      return $urandom_range(0, 1) ? gwwu_pkg::CH_SPACE : gwwu_pkg::CH_NEWLINE;
   endfunction

   // Mostly well-formed words with separator runs, some paragraph ends and noise
   function automatic void add_text(int n_items, int max_len);
      int made;
      int len;
      int seps;
      int eop_mode;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 7) != 0) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(WORD_CAP - 3, WORD_CAP + 8)
                                               : $urandom_range(1, max_len);
            // 0: none, 1: on last word byte, 2: on the last separator
            eop_mode = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < len; i++) add_item(word_byte(), eop_mode == 1 && i == len - 1);
            made += len;
            seps = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
            for (int i = 0; i < seps; i++) add_item(separator(), eop_mode == 2 && i == seps - 1);
            if (eop_mode != 0) made++;
         end else begin
            case ($urandom_range(0, 2))
               0: add_item(separator(), 1'b1);
               1: add_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               default: add_item(separator(), 1'b0);
            endcase
            made++;
         end
      end
   endfunction

   task automatic wait_drained();
      while (accepted_count != pushed_count || wrapped_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_width(input logic [7:0] w);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LINE_WIDTH_ADDR;
      csr_pwdata <= {24'd0, w};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      line_width = w;
   endtask

   task automatic run_phase(input logic [7:0] w, input int max_len, input int n_items);
      write_line_width(w);
      add_text(n_items, max_len);
      wait_drained();
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.in_char = 8'd0;
      req_if.end_of_paragraph = 1'b0;
      rsp_if.ready = 1'b0;
      pushed_count = 0;
      accepted_count = 0;
      error_count = 0;
      cycle_count = 0;
      send_calm = 1'b0;
      rsp_calm = 1'b0;
      rsp_stall = 0;
      word_len = 0;
      line_len = 8'd0;
      at_line_start = 1'b1;
      line_width = gwwu_pkg::LINE_WIDTH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset width: empty paragraph, byte extremes, collapsing separators
      add_item(gwwu_pkg::CH_SPACE, 1'b1);
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(gwwu_pkg::CH_SPACE, 1'b0);
      add_item(gwwu_pkg::CH_SPACE, 1'b0);
      add_item(gwwu_pkg::CH_NEWLINE, 1'b0);
      add_item(8'h7F, 1'b0);
      add_item(8'h80, 1'b0);
      add_item(gwwu_pkg::CH_NEWLINE, 1'b1);
      add_item(8'h01, 1'b1);
      add_item(8'hFE, 1'b0);
      add_item(gwwu_pkg::CH_SPACE, 1'b0);
      add_item(8'h55, 1'b1);
      wait_drained();

      // narrow line: word wider than the line at line start, then breaks
      write_line_width(8'd3);
      add_item("a", 1'b0);
      add_item("b", 1'b0);
      add_item("c", 1'b0);
      add_item("d", 1'b0);
      add_item(gwwu_pkg::CH_SPACE, 1'b0);
      add_item("e", 1'b0);
      add_item("f", 1'b0);
      add_item(gwwu_pkg::CH_NEWLINE, 1'b0);
      add_item("g", 1'b1);
      add_item(gwwu_pkg::CH_NEWLINE, 1'b1);
      wait_drained();

      // random text across several widths, extremes included
      run_phase(8'd255, WORD_CAP, 45);
      run_phase(8'd1, 6, 20);
      run_phase(8'd0, 5, 15);
      run_phase(8'd17, 9, 30);
      run_phase(8'd80, 12, 30);
      run_phase(8'($urandom_range(2, 40)), 10, 35);

      if (error_count == 0) begin
         $display("greedy_word_wrap_unit verification clean");
      end else begin
         $display("greedy_word_wrap_unit verification failed");
      end
      $finish;
   end

endmodule

[greedy_word_wrap_unit.f]
design/gwwu_pkg.sv
design/gwwu_ifs.sv
design/gwwu_word_mem.sv
design/gwwu_ctrl.sv
design/greedy_word_wrap_unit.sv
tb/sv/tb.sv
